@@ sv/s2a_pkg.sv @@
`timescale 1ns / 1ps

package s2a_pkg;

  localparam logic [7:0] PREFIX_CODE = 8'hE0;
  localparam logic [6:0] LSHIFT_CODE = 7'h2A;
  localparam logic [6:0] RSHIFT_CODE = 7'h36;
  localparam logic [6:0] CAPS_CODE   = 7'h3A;
  localparam logic [7:0] TABLE_SIZE  = 8'd59;
  localparam logic [6:0] NO_CHAR     = 7'h00;

  typedef logic [6:0] ascii_t;

  typedef struct packed {
    logic lshift;
    logic rshift;
    logic caps;
    logic prefix;
  } key_flags_t;

  function automatic ascii_t plain_char(input logic [5:0] code);
    ascii_t c;
    case (code)
      6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;  6'h05: c = 7'h34;
      6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;  6'h09: c = 7'h38;
      6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;  6'h0D: c = 7'h3D;
      6'h0E: c = 7'h08;  6'h0F: c = 7'h09;  6'h10: c = 7'h71;  6'h11: c = 7'h77;
      6'h12: c = 7'h65;  6'h13: c = 7'h72;  6'h14: c = 7'h74;  6'h15: c = 7'h79;
      6'h16: c = 7'h75;  6'h17: c = 7'h69;  6'h18: c = 7'h6F;  6'h19: c = 7'h70;
      6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;  6'h1C: c = 7'h0A;  6'h1E: c = 7'h61;
      6'h1F: c = 7'h73;  6'h20: c = 7'h64;  6'h21: c = 7'h66;  6'h22: c = 7'h67;
      6'h23: c = 7'h68;  6'h24: c = 7'h6A;  6'h25: c = 7'h6B;  6'h26: c = 7'h6C;
      6'h27: c = 7'h3B;  6'h28: c = 7'h27;  6'h29: c = 7'h60;  6'h2B: c = 7'h5C;
      6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;  6'h2E: c = 7'h63;  6'h2F: c = 7'h76;
      6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;  6'h33: c = 7'h2C;
      6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h37: c = 7'h2A;  6'h39: c = 7'h20;
      default: c = NO_CHAR;
    endcase
    return c;
  endfunction

  function automatic ascii_t shift_char(input logic [5:0] code);
    ascii_t c;
    case (code)
      6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
      6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
      6'h0E: c = 7'h08;  6'h0F: c = 7'h09;  6'h10: c = 7'h51;  6'h11: c = 7'h57;
      6'h12: c = 7'h45;  6'h13: c = 7'h52;  6'h14: c = 7'h54;  6'h15: c = 7'h59;
      6'h16: c = 7'h55;  6'h17: c = 7'h49;  6'h18: c = 7'h4F;  6'h19: c = 7'h50;
      6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;  6'h1C: c = 7'h0A;  6'h1E: c = 7'h41;
      6'h1F: c = 7'h53;  6'h20: c = 7'h44;  6'h21: c = 7'h46;  6'h22: c = 7'h47;
      6'h23: c = 7'h48;  6'h24: c = 7'h4A;  6'h25: c = 7'h4B;  6'h26: c = 7'h4C;
      6'h27: c = 7'h3A;  6'h28: c = 7'h22;  6'h29: c = 7'h7E;  6'h2B: c = 7'h7C;
      6'h2C: c = 7'h5A;  6'h2D: c = 7'h58;  6'h2E: c = 7'h43;  6'h2F: c = 7'h56;
      6'h30: c = 7'h42;  6'h31: c = 7'h4E;  6'h32: c = 7'h4D;  6'h33: c = 7'h3C;
      6'h34: c = 7'h3E;  6'h35: c = 7'h3F;  6'h37: c = 7'h2A;  6'h39: c = 7'h20;
      default: c = NO_CHAR;
    endcase
    return c;
  endfunction

endpackage

@@ sv/s2a_if.sv @@
`timescale 1ns / 1ps

interface s2a_in_if;
  logic       valid;
  logic       ready;
  logic       data_ready;
  logic [7:0] scan_byte;

  modport source (output valid, output data_ready, output scan_byte, input ready);
  modport sink   (input valid, input data_ready, input scan_byte, output ready);
endinterface

interface s2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink   (input valid, input ascii_char, output ready);
endinterface

@@ sv/s2a_decode.sv @@
`timescale 1ns / 1ps

module s2a_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          scan_byte,
  output logic                emit,
  output s2a_pkg::ascii_t     ascii_char
);

  s2a_pkg::key_flags_t flags_r;
  s2a_pkg::key_flags_t flags_nxt;
  s2a_pkg::ascii_t     base;
  s2a_pkg::ascii_t     shifted;
  logic                upper;

  always_comb begin
    flags_nxt  = flags_r;
    emit       = 1'b0;
    base       = s2a_pkg::plain_char(scan_byte[5:0]);
    shifted    = s2a_pkg::shift_char(scan_byte[5:0]);
    upper      = flags_r.lshift | flags_r.rshift;
    if (base inside {[7'h61:7'h7A]}) begin
      upper = upper ^ flags_r.caps;
    end
    ascii_char = upper ? shifted : base;

    if (scan_byte == s2a_pkg::PREFIX_CODE) begin
      flags_nxt.prefix = 1'b1;
    end else if (flags_r.prefix) begin
      flags_nxt.prefix = 1'b0;
    end else if (scan_byte[7]) begin
      if (scan_byte[6:0] == s2a_pkg::LSHIFT_CODE) begin
        flags_nxt.lshift = 1'b0;
      end else if (scan_byte[6:0] == s2a_pkg::RSHIFT_CODE) begin
        flags_nxt.rshift = 1'b0;
      end
    end else if (scan_byte[6:0] == s2a_pkg::LSHIFT_CODE) begin
      flags_nxt.lshift = 1'b1;
    end else if (scan_byte[6:0] == s2a_pkg::RSHIFT_CODE) begin
      flags_nxt.rshift = 1'b1;
    end else if (scan_byte[6:0] == s2a_pkg::CAPS_CODE) begin
      flags_nxt.caps = ~flags_r.caps;
    end else if (scan_byte < s2a_pkg::TABLE_SIZE) begin
      emit = (ascii_char != s2a_pkg::NO_CHAR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (advance) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

@@ sv/scancode_to_ascii_decoder.sv @@
`timescale 1ns / 1ps

// Set 1 scancode to ASCII decoder.
// in_bus: valid/ready channel carrying data_ready and scan_byte. A beat with
//   data_ready low is taken and dropped without touching the decode flags.
// out_bus: valid/ready channel carrying ascii_char, one beat per byte that
//   decodes to a character; prefix, shift, caps and break bytes give none.
// Path: a byte taken goes into the input register, then through decode and
//   table lookup into the output register, which drives out_bus.
//   Throughput: one byte per cycle while out_bus keeps up.
// Stall: the output register holds its beat while out_bus.ready is low. The
//   input register keeps taking bytes that give no character; a byte that
//   does waits there, and in_bus.ready drops until the output frees up.
// Reset (rst_n low, synchronous): shift, caps and prefix flags clear, both
//   registers empty, in_bus.ready is held low.

module scancode_to_ascii_decoder (
  input  logic             clk,
  input  logic             rst_n,
  s2a_in_if.sink           in_bus,
  s2a_out_if.source        out_bus
);

  logic            stg_v_r;
  logic            stg_v_nxt;
  logic [7:0]      stg_byte_r;
  logic            out_v_r;
  logic            out_v_nxt;
  s2a_pkg::ascii_t out_char_r;
  logic            emit;
  s2a_pkg::ascii_t dec_char;
  logic            out_free;
  logic            advance;
  logic            in_take;

  s2a_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .scan_byte  (stg_byte_r),
    .emit       (emit),
    .ascii_char (dec_char)
  );

  assign out_free     = !out_v_r || out_bus.ready;
  assign advance      = stg_v_r && (!emit || out_free);
  assign in_bus.ready = rst_n && (!stg_v_r || advance);
  assign in_take      = in_bus.valid && in_bus.ready;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_take) begin
      stg_v_nxt = in_bus.data_ready;
    end else if (advance) begin
      stg_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_bus.scan_byte;
    end
    if (advance && emit) begin
      out_char_r <= dec_char;
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.ascii_char = out_char_r;

endmodule

@@ sv/s2a_checker.sv @@
`timescale 1ns / 1ps

module s2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 7'd8) && (out_char <= 7'd126))
    else $error("character outside decodable range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |-> !in_ready ##1 !out_valid)
    else $error("channels not idle after reset");

  a_rise_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a byte two cycles earlier");

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_char  (out_bus.ascii_char)
);
